[src/mvcl_pkg.sv]
// Package for the mesh vertex component labeling core.
// Holds the microcode word type, step and mode codes, and the control ROM.
// No dependencies.
package mvcl_pkg;

  localparam int LABEL_W = 10;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int STEP_W  = 4;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic [2:0] M_DISPATCH = 3'd0;
  localparam logic [2:0] M_NEXT     = 3'd1;
  localparam logic [2:0] M_JOIN     = 3'd2;
  localparam logic [2:0] M_SWEEP    = 3'd3;
  localparam logic [2:0] M_REPLY    = 3'd4;
  localparam logic [2:0] M_ERR      = 3'd5;
  localparam logic [2:0] M_INIT     = 3'd6;

  localparam logic [1:0] SEL_A   = 2'd0;
  localparam logic [1:0] SEL_B   = 2'd1;
  localparam logic [1:0] SEL_C   = 2'd2;
  localparam logic [1:0] SEL_CNT = 2'd3;

  localparam logic [STEP_W-1:0] S_WAIT   = 4'd0;
  localparam logic [STEP_W-1:0] S_RD_A   = 4'd1;
  localparam logic [STEP_W-1:0] S_RD_B   = 4'd2;
  localparam logic [STEP_W-1:0] S_JOIN1  = 4'd3;
  localparam logic [STEP_W-1:0] S_SWEEP1 = 4'd4;
  localparam logic [STEP_W-1:0] S_RD_B2  = 4'd5;
  localparam logic [STEP_W-1:0] S_RD_C   = 4'd6;
  localparam logic [STEP_W-1:0] S_JOIN2  = 4'd7;
  localparam logic [STEP_W-1:0] S_SWEEP2 = 4'd8;
  localparam logic [STEP_W-1:0] S_RD_LBL = 4'd9;
  localparam logic [STEP_W-1:0] S_REPLY  = 4'd10;
  localparam logic [STEP_W-1:0] S_ERR    = 4'd11;
  localparam logic [STEP_W-1:0] S_INIT   = 4'd12;

  typedef struct packed {
    logic [2:0]        mode;
    logic [1:0]        rd_sel;
    logic              cap_keep;
    logic [STEP_W-1:0] tgt;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{mode: M_DISPATCH, rd_sel: SEL_A, cap_keep: 1'b0, tgt: S_WAIT};
    unique case (step)
      S_WAIT:   w = '{mode: M_DISPATCH, rd_sel: SEL_A,   cap_keep: 1'b0, tgt: S_RD_A};
      S_RD_A:   w = '{mode: M_NEXT,     rd_sel: SEL_A,   cap_keep: 1'b0, tgt: S_RD_B};
      S_RD_B:   w = '{mode: M_NEXT,     rd_sel: SEL_B,   cap_keep: 1'b1, tgt: S_JOIN1};
      S_JOIN1:  w = '{mode: M_JOIN,     rd_sel: SEL_B,   cap_keep: 1'b0, tgt: S_RD_B2};
      S_SWEEP1: w = '{mode: M_SWEEP,    rd_sel: SEL_CNT, cap_keep: 1'b0, tgt: S_RD_B2};
      S_RD_B2:  w = '{mode: M_NEXT,     rd_sel: SEL_B,   cap_keep: 1'b0, tgt: S_RD_C};
      S_RD_C:   w = '{mode: M_NEXT,     rd_sel: SEL_C,   cap_keep: 1'b1, tgt: S_JOIN2};
      S_JOIN2:  w = '{mode: M_JOIN,     rd_sel: SEL_C,   cap_keep: 1'b0, tgt: S_RD_LBL};
      S_SWEEP2: w = '{mode: M_SWEEP,    rd_sel: SEL_CNT, cap_keep: 1'b0, tgt: S_RD_LBL};
      S_RD_LBL: w = '{mode: M_NEXT,     rd_sel: SEL_A,   cap_keep: 1'b0, tgt: S_REPLY};
      S_REPLY:  w = '{mode: M_REPLY,    rd_sel: SEL_A,   cap_keep: 1'b0, tgt: S_WAIT};
      S_ERR:    w = '{mode: M_ERR,      rd_sel: SEL_A,   cap_keep: 1'b0, tgt: S_WAIT};
      S_INIT:   w = '{mode: M_INIT,     rd_sel: SEL_A,   cap_keep: 1'b0, tgt: S_WAIT};
      default:  w = '{mode: M_INIT,     rd_sel: SEL_A,   cap_keep: 1'b0, tgt: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

[src/mvcl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvcl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mesh_vertex_component_labeling_core.sv]
// Mesh vertex component labeling core: quick-find labels in one RAM, run by a microcoded
// sequencer. Depends on mvcl_pkg and mvcl_ram.
//
// channel  | signals                                     | direction
// in       | in_valid, in_ready, opcode, vertex_a/b/c    | in
// out      | out_valid, out_ready, label, merges_done,   | out
//          | index_error                                 |
// cfg      | cfg_valid, cfg_ready, cfg_vertex_count      | in
//
// A merge runs up to two joins; a join that finds two different labels is followed by a
// label sweep over DEPTH entries, DEPTH = min(MAX_VERTICES, 1024), one entry per cycle on
// the single RAM write port.
// The result turns valid at the edge that returns the sequencer to dispatch.
// Reset loads every label with its own index in a pass over all DEPTH entries; no transaction
// is taken on meanwhile.
// A stalled result holds the sequencer in its reply or error step; cfg is always ready.
module mesh_vertex_component_labeling_core import mvcl_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  input  logic [INDEX_W-1:0]  vertex_a,
  input  logic [INDEX_W-1:0]  vertex_b,
  input  logic [INDEX_W-1:0]  vertex_c,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LABEL_W-1:0]  label,
  output logic [1:0]          merges_done,
  output logic                index_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_vertex_count
);

  localparam int DEPTH = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam logic [COUNT_W-1:0] DEPTH_N  = COUNT_W'(DEPTH);
  localparam logic [CW-1:0]      CNT_END  = CW'(DEPTH);
  localparam logic [CW-1:0]      CNT_LAST = CW'(DEPTH - 1);

  logic [STEP_W-1:0]  step, step_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [COUNT_W-1:0] vertex_count;
  logic [INDEX_W-1:0] a, b, c;
  logic [LABEL_W-1:0] keep, gone;
  logic [1:0]         merges;
  logic               pv;
  logic [AW-1:0]      wa;
  ctrl_t              cw;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [LABEL_W-1:0] ram_wdata, ram_rdata;

  logic [COUNT_W-1:0] lim;
  logic               in_bad, accept, issue, out_free, sweep_end;

  assign cw        = ucode(step);
  assign in_ready  = (cw.mode == M_DISPATCH);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign issue     = (cw.mode == M_SWEEP) && (cnt != CNT_END);
  assign sweep_end = (cw.mode == M_SWEEP) && (cnt == CNT_END);

  assign lim    = (vertex_count > DEPTH_N) ? DEPTH_N : vertex_count;
  assign in_bad = !({1'b0, vertex_a} < lim) ||
                  (!opcode && (!({1'b0, vertex_b} < lim) || !({1'b0, vertex_c} < lim)));

  always_comb begin
    case (cw.rd_sel)
      SEL_A:   ram_raddr = a[AW-1:0];
      SEL_B:   ram_raddr = b[AW-1:0];
      SEL_C:   ram_raddr = c[AW-1:0];
      default: ram_raddr = cnt[AW-1:0];
    endcase
  end

  always_comb begin
    if (cw.mode == M_INIT) begin
      ram_we    = 1'b1;
      ram_waddr = cnt[AW-1:0];
      ram_wdata = LABEL_W'(cnt[AW-1:0]);
    end else begin
      ram_we    = pv && (ram_rdata == gone);
      ram_waddr = wa;
      ram_wdata = keep;
    end
  end

  always_comb begin
    step_next = step;
    cnt_next  = cnt;
    unique case (cw.mode) inside
      M_DISPATCH: begin
        if (in_valid) begin
          if (in_bad) begin
            step_next = S_ERR;
          end else if (opcode) begin
            step_next = S_RD_LBL;
          end else begin
            step_next = cw.tgt;
          end
        end
      end
      M_NEXT: step_next = cw.tgt;
      M_JOIN: begin
        cnt_next  = '0;
        step_next = (keep == ram_rdata) ? cw.tgt : step + STEP_W'(1);
      end
      M_SWEEP: begin
        if (issue) begin
          cnt_next = cnt + CW'(1);
        end else begin
          step_next = cw.tgt;
        end
      end
      M_REPLY, M_ERR: begin
        if (out_free) begin
          step_next = cw.tgt;
        end
      end
      M_INIT: begin
        cnt_next = cnt + CW'(1);
        if (cnt == CNT_LAST) begin
          step_next = cw.tgt;
        end
      end
      default: step_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= S_INIT;
      cnt          <= '0;
      pv           <= 1'b0;
      out_valid    <= 1'b0;
      vertex_count <= COUNT_RESET;
    end else begin
      step <= step_next;
      cnt  <= cnt_next;
      pv   <= issue;
      if (cfg_valid) begin
        vertex_count <= cfg_vertex_count;
      end
      if ((cw.mode == M_REPLY || cw.mode == M_ERR) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wa <= cnt[AW-1:0];
    if (accept) begin
      a      <= vertex_a;
      b      <= vertex_b;
      c      <= vertex_c;
      merges <= 2'd0;
    end
    if (cw.cap_keep) begin
      keep <= ram_rdata;
    end
    if (cw.mode == M_JOIN) begin
      gone <= ram_rdata;
    end
    if (sweep_end) begin
      merges <= merges + 2'd1;
    end
    if (cw.mode == M_REPLY && out_free) begin
      label       <= ram_rdata;
      merges_done <= merges;
      index_error <= 1'b0;
    end else if (cw.mode == M_ERR && out_free) begin
      label       <= '0;
      merges_done <= 2'd0;
      index_error <= 1'b1;
    end
  end

  mvcl_ram #(
    .WIDTH(LABEL_W),
    .DEPTH(DEPTH)
  ) u_labels (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`ifndef SYNTH
  a_accept_leaves_wait: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("sequencer stayed in dispatch after a transaction");

  a_merges_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> merges_done != 2'd3)
    else $error("merge count out of range");

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> label == '0 && merges_done == 2'd0)
    else $error("error result carries data");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (cw.mode == M_SWEEP || cw.mode == M_INIT))
    else $error("label write outside sweep or clearing pass");

  a_pending_in_sweep: assert property (@(posedge clk) disable iff (rst)
    pv |-> cw.mode == M_SWEEP)
    else $error("sweep write pending outside sweep step");
`endif

endmodule
